/* rtl/dmx_frame_receiver_self_address_defines.svh */
// ----------------------------------------------------------------------------
// DMX frame receiver assertion macros
// Shared concurrent check forms, clocked on clk_i and held off during reset.
// ----------------------------------------------------------------------------
`ifndef DMX_FRAME_RECEIVER_SELF_ADDRESS_DEFINES_SVH
`define DMX_FRAME_RECEIVER_SELF_ADDRESS_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DMXR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define DMXR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/dmxr_pkg.sv */
// ----------------------------------------------------------------------------
// DMX frame receiver package
// Types, configuration codes and sizing constants shared by the receiver.
// ----------------------------------------------------------------------------
package dmxr_pkg;

  // Forwarding buffer size, fixture window size and address slot
  localparam int unsigned ChannelsOut    = 512;
  localparam int unsigned RegsPerFixture = 8;
  localparam int unsigned MaxFixtures    = 16;
  localparam int unsigned AddressSlot    = 0;

  localparam int unsigned SlotW = 10;
  localparam logic [SlotW-1:0] SlotMax = '1;
  localparam int unsigned WinW = 13;
  localparam logic [WinW-1:0] WinLimit = WinW'(RegsPerFixture * MaxFixtures);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SELF_ADDRESSING = 1'b0,
    CFG_FIXTURE_NUMBER  = 1'b1
  } cfg_idx_e;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_START = 2'd1,
    PH_FRAME = 2'd2
  } phase_e;

  typedef struct packed {
    logic       self_addressing;
    logic [3:0] fixture_number;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_error;
  } item_t;

  typedef struct packed {
    logic       frame_start;
    logic       out_write;
    logic [8:0] out_slot;
    logic [7:0] out_value;
    logic       reg_write;
    logic [2:0] reg_slot;
    logic [7:0] reg_value;
    logic [7:0] base_now;
  } result_t;

endpackage

/* rtl/dmxr_stream_if.sv */
// ----------------------------------------------------------------------------
// DMX frame receiver stream interface
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface dmxr_stream_if #(
  parameter type T = logic [7:0]
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/dmxr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// DMX frame receiver configuration registers
// Holds the addressing mode and the switch fixture number.
// ----------------------------------------------------------------------------
module dmxr_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  dmxr_pkg::cfg_idx_e cfg_idx_i,
  input  logic [3:0]        cfg_wdata_i,
  output dmxr_pkg::cfg_t    cfg_o
);
  import dmxr_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SELF_ADDRESSING: cfg_d.self_addressing = cfg_wdata_i[0];
        CFG_FIXTURE_NUMBER:  cfg_d.fixture_number  = cfg_wdata_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.self_addressing <= 1'b1;
      cfg_q.fixture_number  <= 4'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/dmxr_slot_engine.sv */
// ----------------------------------------------------------------------------
// DMX frame receiver slot engine
// Tracks break/start code/frame phase, counts slots and decodes the windows.
// ----------------------------------------------------------------------------
`include "dmx_frame_receiver_self_address_defines.svh"

module dmxr_slot_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dmxr_pkg::cfg_t    cfg_i,
  input  logic              step_i,
  input  dmxr_pkg::item_t   item_i,
  output dmxr_pkg::result_t result_o
);
  import dmxr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [7:0]       base_q, base_d;

  logic [SlotW-1:0] base_ext;
  logic [SlotW-1:0] reg_off;
  logic             in_window;
  logic             in_forward;
  logic             is_addr_slot;
  result_t          res;

  // Window decode on the current slot
  always_comb begin
    base_ext     = {{(SlotW-8){1'b0}}, base_q};
    reg_off      = slot_q - base_ext;
    in_window    = ({{(WinW-SlotW){1'b0}}, slot_q} < WinLimit) &&
                   (slot_q >= base_ext) &&
                   (reg_off < SlotW'(RegsPerFixture));
    in_forward   = slot_q < SlotW'(ChannelsOut);
    is_addr_slot = slot_q == SlotW'(AddressSlot);
  end

  // Next state and result for the byte at hand
  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    base_d  = base_q;
    res     = '0;
    if (item_i.frame_error) begin
      phase_d = PH_START;
    end else begin
      case (phase_q)
        PH_START: begin
          if (item_i.rx_byte == 8'd0) begin
            phase_d         = PH_FRAME;
            slot_d          = '0;
            res.frame_start = 1'b1;
            if (!cfg_i.self_addressing) begin
              base_d = 8'({4'd0, cfg_i.fixture_number} * 8'(RegsPerFixture));
            end
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_FRAME: begin
          if (in_window) begin
            res.reg_write = 1'b1;
            res.reg_slot  = reg_off[2:0];
            res.reg_value = item_i.rx_byte;
          end
          if (in_forward) begin
            res.out_write = 1'b1;
            res.out_slot  = slot_q[8:0];
            res.out_value = item_i.rx_byte;
          end
          if (cfg_i.self_addressing && is_addr_slot) begin
            base_d = item_i.rx_byte;
            if (in_forward) begin
              res.out_value = item_i.rx_byte + 8'(RegsPerFixture);
            end
          end
          if (slot_q != SlotMax) begin
            slot_d = slot_q + 1'b1;
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
    res.base_now = base_d;
  end

  // Advance state only on a processed byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      slot_q  <= '0;
      base_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      base_q  <= base_d;
    end
  end

  assign result_o = res;

  `DMXR_ASSERT_NEXT(a_break_arms, step_i && item_i.frame_error, phase_q == PH_START)
  `DMXR_ASSERT_NEXT(a_slot_advance,
                    step_i && !item_i.frame_error && phase_q == PH_FRAME && slot_q != SlotMax,
                    slot_q == $past(slot_q) + 1'b1)
  `DMXR_ASSERT_NOW(a_start_no_write, res.frame_start, !res.out_write && !res.reg_write)
  `DMXR_ASSERT_NEXT(a_base_hold, !step_i, $stable(base_q))

endmodule

/* rtl/dmx_frame_receiver_self_address.sv */
// ----------------------------------------------------------------------------
// DMX frame receiver with self-addressing
// Turns received DMX512 bytes into register and forwarding write reports.
// ----------------------------------------------------------------------------
// Takes one received byte per request and returns exactly one result per byte.
// Throughput is one byte per cycle while the result side is ready. A byte is
// held in the input register and is decoded into the result register once that
// register is empty or being drained; its result is then offered from the result
// register until taken. The input side stays ready while the result register
// is empty or being drained, or while the input register is empty, so ready
// follows the result side's ready in the same cycle. Configuration writes take
// effect on the next byte processed.
module dmx_frame_receiver_self_address (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dmxr_pkg::cfg_idx_e cfg_idx_i,
  input  logic [3:0]         cfg_wdata_i,
  dmxr_stream_if.sink        item_i,
  dmxr_stream_if.source      result_o
);
  import dmxr_pkg::*;

  cfg_t    cfg;
  result_t res;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    advance;

  // Move the held byte forward when the result register frees up
  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;

  dmxr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  dmxr_slot_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (advance),
    .item_i   (in_item_q),
    .result_o (res)
  );

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      in_item_q <= item_i.data;
    end
  end

  // Result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_res_q;

endmodule
